@@ hdl/assert_macros.svh @@
// Assertion macros used by the deque top level.
// No dependencies; each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

@@ hdl/deq_pkg.sv @@
// Types and constants for the double-ended queue.
// No dependencies; used by the deque top level, controller and datapath.
package deq_pkg;

    localparam int DEQ_DEPTH  = 32;
    localparam int DEQ_WORD_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST_FWD   = 3'd4,
        CMD_LIST_BWD   = 3'd5
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]                   command;
        logic signed [DEQ_WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                      status;
        logic signed [DEQ_WORD_W-1:0] element;
        logic                         has_element;
        logic                         last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic    ins_front;
        logic    ins_back;
        logic    del_front;
        logic    del_back;
        logic    list_start;
        logic    list_back;
        logic    list_step;
        logic    res_valid;
        t_status res_status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
    } t_dp_stat;

endpackage

@@ hdl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_ctrl, deq_datapath (and deq_ram), assert_macros.svh.
//
//  channel   handshake               payload     direction
//  command   i_start / o_busy        i_cmd       in   (taken when i_start && !o_busy)
//  result    o_strobe (one cycle)    o_result    out  (taken at the end of that cycle)
//
// Push and pop: one item per cycle while not busy, result in the cycle after acceptance.
// List of n > 0 entries: busy after acceptance until all n are read (one store read per
// cycle through the single RAM read port), each result in the cycle after its read.
// List of an empty queue: one result, like a pop.
// Synchronous active-low reset empties the queue; store contents stay undefined.
// Results cannot be held off by the receiver.
`include "assert_macros.svh"

module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_cmd,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    deq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_cmd.command),
        .i_stat    (dp_stat),
        .o_busy    (o_busy),
        .o_cmd     (dp_cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_value  (i_cmd.value),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // during a walk only listed elements come out
    `ASSERT_IMP(a_walk_elements, o_busy && o_strobe, o_result.has_element)
    // an item without an element is always the only one of its command
    `ASSERT_IMP(a_status_single, o_strobe && !o_result.has_element, o_result.last)
    // listed elements carry an ok status
    `ASSERT_IMP(a_element_ok, o_strobe && o_result.has_element, o_result.status == ST_OK)
    // push and pop answer in the next cycle with a single item
    `ASSERT_NEXT(a_pushpop_answer, i_start && !o_busy && (i_cmd.command == CMD_PUSH_FRONT ||
        i_cmd.command == CMD_PUSH_BACK || i_cmd.command == CMD_POP_FRONT ||
        i_cmd.command == CMD_POP_BACK), o_strobe && o_result.last && !o_result.has_element)

endmodule

@@ hdl/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/deq_datapath.sv @@
// Deque datapath: ring pointers, listing walk counters, store RAM, result registers.
// Depends on deq_pkg and deq_ram.
module deq_datapath import deq_pkg::*; #(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  logic signed [DEQ_WORD_W-1:0] i_value,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    // (a + b) mod DEPTH for a, b below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_occ, n_occ;
    logic [AW-1:0] r_off, n_off;
    logic [CW-1:0] r_left, n_left;
    logic          r_back, n_back;
    logic          r_res_valid;
    t_status       r_res_status;
    logic          r_rd_valid;
    logic          r_rd_last;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DEQ_WORD_W-1:0] ram_rdata;
    logic [AW-1:0]         front_dec;

    assign front_dec = (r_front == '0) ? LAST_POS : r_front - 1'b1;

    // pointer and walk updates
    always_comb begin
        n_front   = r_front;
        n_occ     = r_occ;
        n_off     = r_off;
        n_left    = r_left;
        n_back    = r_back;
        ram_we    = 1'b0;
        ram_waddr = ring_add(r_front, r_occ[AW-1:0]);
        if (i_cmd.ins_front) begin
            n_front   = front_dec;
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            n_occ     = r_occ + 1'b1;
        end
        if (i_cmd.ins_back) begin
            ram_we = 1'b1;
            n_occ  = r_occ + 1'b1;
        end
        if (i_cmd.del_front) begin
            n_front = ring_add(r_front, AW'(1));
            n_occ   = r_occ - 1'b1;
        end
        if (i_cmd.del_back) begin
            n_occ = r_occ - 1'b1;
        end
        if (i_cmd.list_start) begin
            n_back = i_cmd.list_back;
            n_left = r_occ;
            n_off  = i_cmd.list_back ? AW'(r_occ - 1'b1) : '0;
        end
        if (i_cmd.list_step) begin
            n_left = r_left - 1'b1;
            n_off  = r_back ? r_off - 1'b1 : r_off + 1'b1;
        end
    end

    assign ram_raddr = ring_add(r_front, r_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_occ       <= '0;
            r_left      <= '0;
            r_res_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_left      <= n_left;
            r_res_valid <= i_cmd.res_valid;
            r_rd_valid  <= i_cmd.list_step;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_off        <= n_off;
        r_back       <= n_back;
        r_res_status <= i_cmd.res_status;
        r_rd_last    <= (r_left == CW'(1));
    end

    deq_ram #(
        .WIDTH (DEQ_WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // status to the controller
    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.full      = (r_occ == DEPTH_C);
    assign o_stat.walk_last = (r_left == CW'(1));

    // result item: listed element or status answer, never both in one cycle
    assign o_strobe             = r_rd_valid | r_res_valid;
    assign o_result.status      = r_rd_valid ? ST_OK : r_res_status;
    assign o_result.element     = r_rd_valid ? ram_rdata : '0;
    assign o_result.has_element = r_rd_valid;
    assign o_result.last        = r_rd_valid ? r_rd_last : 1'b1;

endmodule

@@ hdl/deq_ctrl.sv @@
// Deque controller: decodes commands and sequences the listing walk.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_command,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_stat.empty &&
                    (i_command == CMD_LIST_FWD || i_command == CMD_LIST_BWD)) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_busy           = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            o_cmd.res_valid = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.res_status = ST_FULL;
                            end else begin
                                o_cmd.ins_front = (i_command == CMD_PUSH_FRONT);
                                o_cmd.ins_back  = (i_command == CMD_PUSH_BACK);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            o_cmd.res_valid = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.del_front = (i_command == CMD_POP_FRONT);
                                o_cmd.del_back  = (i_command == CMD_POP_BACK);
                            end
                        end
                        CMD_LIST_FWD, CMD_LIST_BWD: begin
                            if (i_stat.empty) begin
                                o_cmd.res_valid  = 1'b1;
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.list_start = 1'b1;
                                o_cmd.list_back  = (i_command == CMD_LIST_BWD);
                            end
                        end
                        default: ;  // undefined command: no effect, no item
                    endcase
                end
            end
            S_LIST: begin
                o_busy          = 1'b1;
                o_cmd.list_step = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule
